// File: rtl/core/wptd_pkg.sv
`timescale 1ns / 1ps
// wptd_pkg: types and constants shared by the windowed peak tempo detector.
// No dependencies; every other file of the block imports it.
package wptd_pkg;

  localparam int SampleW    = 16;
  localparam int NbrW       = 4;
  localparam int ScaleW     = 16;
  localparam int TempoW     = 24;
  localparam int FracW      = 8;
  localparam int DistW      = 32;
  localparam int CountW     = 24;
  localparam int PosW       = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] CfgThreshold  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNeighbors  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTempoScale = 2'd2;

  localparam logic signed [SampleW-1:0] ThresholdRst  = 16'sd3277;
  localparam logic [NbrW-1:0]           NeighborsRst  = 4'd4;
  localparam logic [ScaleW-1:0]         TempoScaleRst = 16'd2646;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      frame_end;
  } in_t;

  typedef struct packed {
    logic              is_summary;
    logic              peak_found;
    logic [TempoW-1:0] tempo_q8;
    logic              last;
  } out_t;

  typedef struct packed {
    logic signed [SampleW-1:0] threshold;
    logic [NbrW-1:0]           neighbors;
    logic [ScaleW-1:0]         tempo_scale;
  } cfg_t;

  // One unit of work for the back end: a sample decision or a frame summary.
  typedef struct packed {
    logic is_summary;
    logic above;
    logic peak;
    logic last;
  } job_t;

endpackage

// File: rtl/core/wptd_front.sv
`timescale 1ns / 1ps
// wptd_front: input side. Holds the sample window and frame position and turns
// each accepted word into peak decision jobs and frame summary jobs. Uses wptd_pkg.
module wptd_front #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wptd_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wptd_pkg::in_t  in_data_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output wptd_pkg::job_t job_o
);
  import wptd_pkg::*;

  localparam int WinDepth = 2 * MAX_NEIGHBORS + 1;
  localparam int AgeW     = $clog2(WinDepth);
  localparam logic [AgeW-1:0] MaxN = AgeW'(MAX_NEIGHBORS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DEC  = 3'b010,
    F_SUM  = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;

  logic signed [SampleW-1:0] win_q [WinDepth];
  logic [PosW-1:0]           pos_q, pos_d;
  logic [PosW-1:0]           item_pos_q;
  logic [AgeW-1:0]           n_q, age_q, age_d;
  logic                      end_q;

  logic                      accept;
  logic                      done;
  logic [AgeW-1:0]           n_cfg;
  logic [AgeW-1:0]           top_age;
  logic signed [SampleW-1:0] v;
  logic [AgeW-1:0]           hi_full, hi, lo;
  logic                      peak, above;

  assign n_cfg = ({1'b0, cfg_i.neighbors} > 5'(MAX_NEIGHBORS)) ? MaxN
                                                               : AgeW'(cfg_i.neighbors);
  assign top_age = (pos_q < PosW'(n_cfg)) ? pos_q[AgeW-1:0] : n_cfg;

  // Peak test of the sample at age_q against its window clipped to the frame.
  always_comb begin
    v       = win_q[age_q];
    hi_full = age_q + n_q;
    hi      = (item_pos_q < PosW'(hi_full)) ? item_pos_q[AgeW-1:0] : hi_full;
    lo      = (age_q >= n_q) ? age_q - n_q : '0;
    peak    = 1'b1;
    for (int a = 0; a < WinDepth; a++) begin
      if (AgeW'(a) >= lo && AgeW'(a) <= hi && AgeW'(a) != age_q && v <= win_q[a]) begin
        peak = 1'b0;
      end
    end
    above = v >= cfg_i.threshold;
  end

  assign job_valid_o = (state_q == F_DEC) || (state_q == F_SUM);

  always_comb begin
    job_o            = '0;
    job_o.is_summary = (state_q == F_SUM);
    job_o.above      = above;
    job_o.peak       = peak;
    job_o.last       = (state_q == F_SUM) || !end_q;
  end

  assign done = job_ready_i && (((state_q == F_DEC) && !end_q) || (state_q == F_SUM));
  assign in_ready_o = (state_q == F_IDLE) || done;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    age_d   = age_q;
    pos_d   = pos_q;
    case (state_q)
      F_DEC: begin
        if (job_ready_i && end_q) begin
          if (age_q == '0) begin
            state_d = F_SUM;
          end else begin
            age_d = age_q - 1'b1;
          end
        end else if (done) begin
          state_d = F_IDLE;
        end
      end
      F_SUM: begin
        if (done) begin
          state_d = F_IDLE;
        end
      end
      default: ;
    endcase
    if (accept) begin
      if (in_data_i.frame_end) begin
        state_d = F_DEC;
        age_d   = top_age;
        pos_d   = '0;
      end else begin
        state_d = (pos_q >= PosW'(n_cfg)) ? F_DEC : F_IDLE;
        age_d   = n_cfg;
        pos_d   = (pos_q == '1) ? pos_q : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      pos_q      <= '0;
      item_pos_q <= '0;
      n_q        <= '0;
      age_q      <= '0;
      end_q      <= 1'b0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      age_q   <= age_d;
      pos_q   <= pos_d;
      if (accept) begin
        item_pos_q <= pos_q;
        n_q        <= n_cfg;
        end_q      <= in_data_i.frame_end;
        win_q[0]   <= in_data_i.sample;
        for (int i = 1; i < WinDepth; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

endmodule

// File: rtl/core/wptd_queue.sv
`timescale 1ns / 1ps
// wptd_queue: short job queue between the front and the back end.
// Uses wptd_pkg for the job type and depth.
module wptd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  wptd_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wptd_pkg::job_t pop_data_o
);
  import wptd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/wptd_back.sv
`timescale 1ns / 1ps
// wptd_back: executes jobs. Keeps the peak distance statistics, computes the
// tempo with a multiplier and a bit-serial divider, drives the output word. Uses wptd_pkg.
module wptd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wptd_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  wptd_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wptd_pkg::out_t out_data_o
);
  import wptd_pkg::*;

  localparam int ProdW = ScaleW + CountW;
  localparam int StepW = $clog2(TempoW);

  typedef enum logic [4:0] {
    B_RUN = 5'b00001,
    B_MUL = 5'b00010,
    B_CHK = 5'b00100,
    B_DIV = 5'b01000,
    B_FIN = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [DistW-1:0]  counter_q, sum_q;
  logic [CountW-1:0] count_q;
  logic              first_q;
  logic [TempoW-1:0] tempo_q;
  logic [ProdW-1:0]  prod_q;
  logic [DistW-1:0]  rem_q;
  logic [TempoW-1:0] dvd_q, quo_q;
  logic [StepW-1:0]  step_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              slot_free;
  logic              pop;
  logic              load_word;
  logic              hit;
  logic [DistW-1:0]  base;
  logic [DistW:0]    sum_ext;
  logic [DistW:0]    trial;
  logic              ge;
  logic [TempoW-1:0] quo_d;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A decision below threshold makes no word, so it never waits for the output.
  always_comb begin
    pop = 1'b0;
    if (state_q == B_RUN && job_valid_i) begin
      pop = job_i.is_summary || !job_i.above || slot_free;
    end
  end
  assign job_ready_o = pop;

  assign load_word = (pop && !job_i.is_summary && job_i.above) ||
                     (state_q == B_FIN && slot_free);

  assign hit     = !job_i.is_summary && job_i.above && job_i.peak;
  assign base    = hit ? '0 : counter_q;
  assign sum_ext = {1'b0, sum_q} + {1'b0, counter_q};

  assign trial = {rem_q, dvd_q[TempoW-1]};
  assign ge    = trial >= {1'b0, sum_q};
  assign quo_d = {quo_q[TempoW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_RUN: begin
        if (pop && job_i.is_summary) begin
          state_d = (count_q > CountW'(1)) ? B_MUL : B_FIN;
        end
      end
      B_MUL: state_d = B_CHK;
      B_CHK: begin
        if (sum_q == '0 || DistW'(prod_q[ProdW-1:ProdW-TempoW]) >= sum_q) begin
          state_d = B_FIN;
        end else begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (step_q == '0) begin
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        if (slot_free) begin
          state_d = B_RUN;
        end
      end
      default: state_d = B_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_RUN;
      counter_q   <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      first_q     <= 1'b0;
      tempo_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_word) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop && !job_i.is_summary) begin
        if (hit) begin
          if (first_q) begin
            sum_q <= sum_ext[DistW] ? '1 : sum_ext[DistW-1:0];
            if (count_q != '1) begin
              count_q <= count_q + 1'b1;
            end
          end else begin
            first_q <= 1'b1;
          end
        end
        counter_q <= (base == '1) ? base : base + 1'b1;
      end
      if (state_q == B_CHK) begin
        if (sum_q == '0) begin
          tempo_q <= '0;
        end else if (DistW'(prod_q[ProdW-1:ProdW-TempoW]) >= sum_q) begin
          tempo_q <= '1;
        end
      end
      if (state_q == B_DIV && step_q == '0) begin
        tempo_q <= quo_d;
      end
    end
  end

  // Datapath registers: output word, product and divider.
  always_ff @(posedge clk_i) begin
    if (pop && !job_i.is_summary && job_i.above) begin
      out_q.is_summary <= 1'b0;
      out_q.peak_found <= job_i.peak;
      out_q.tempo_q8   <= tempo_q;
      out_q.last       <= job_i.last;
    end else if (state_q == B_FIN && slot_free) begin
      out_q.is_summary <= 1'b1;
      out_q.peak_found <= 1'b0;
      out_q.tempo_q8   <= tempo_q;
      out_q.last       <= 1'b1;
    end
    if (state_q == B_MUL) begin
      prod_q <= ProdW'(cfg_i.tempo_scale) * ProdW'(count_q);
    end
    // The upper dividend half is already below the divisor, so the quotient fits.
    if (state_q == B_CHK) begin
      rem_q  <= DistW'(prod_q[ProdW-1:ProdW-TempoW]);
      dvd_q  <= {prod_q[ProdW-TempoW-1:0], FracW'(0)};
      quo_q  <= '0;
      step_q <= StepW'(TempoW - 1);
    end
    if (state_q == B_DIV) begin
      rem_q  <= ge ? DistW'(trial - {1'b0, sum_q}) : trial[DistW-1:0];
      dvd_q  <= {dvd_q[TempoW-2:0], 1'b0};
      quo_q  <= quo_d;
      step_q <= step_q - 1'b1;
    end
  end

endmodule

// File: rtl/core/windowed_peak_tempo_detector.sv
`timescale 1ns / 1ps
// windowed_peak_tempo_detector: top level with configuration registers.
// Depends on wptd_pkg, wptd_front, wptd_queue and wptd_back.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_data_i: sample, frame_end
//   out     | output    | out_valid_o/out_ready_i| out_data_o: is_summary, peak_found,
//           |           |                        |   tempo_q8, last
//   cfg     | input     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// A word without frame_end gives the front end at most one decision job; a
// frame-end word gives one decision per sample still undecided plus the summary.
// The back end takes jobs only in its run state, so it takes none while it works
// on a summary; a summary with at least two peak distances goes through the
// multiply, the range check and, unless that check settles the tempo, the
// 24-step divider. A four-entry job queue separates the two ends, so an output
// stall fills the queue before input ready drops. Reset loads the register
// defaults and clears the window, frame position and statistics.
module windowed_peak_tempo_detector #(
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wptd_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wptd_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [wptd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wptd_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import wptd_pkg::*;

  cfg_t cfg_q;
  logic job_valid, job_ready, pop_valid, pop_ready;
  job_t job, pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= ThresholdRst;
      cfg_q.neighbors   <= NeighborsRst;
      cfg_q.tempo_scale <= TempoScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold:  cfg_q.threshold   <= cfg_wdata_i[SampleW-1:0];
        CfgNeighbors:  cfg_q.neighbors   <= cfg_wdata_i[NbrW-1:0];
        CfgTempoScale: cfg_q.tempo_scale <= cfg_wdata_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  wptd_front #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  wptd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  wptd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
